// ===== rtl/efws_pkg.sv =====
// Shared constants and types for the earliest-free worker scheduler.
package efws_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int TIME_W          = 63;
    localparam int DUR_W           = 32;
    localparam int WORKER_W        = 4;
    localparam int CNT_W           = 5;

    localparam logic [CNT_W-1:0]  CNT_RESET = 5'd16;
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/efws_cell.sv =====
// One worker cell: holds a free time and refines the passing minimum wave.
module efws_cell
    import efws_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              active,
    input  logic              wave_in_valid,
    input  logic [TIME_W-1:0] wave_in_time,
    input  logic [IDX_W-1:0]  wave_in_idx,
    output logic              wave_out_valid,
    output logic [TIME_W-1:0] wave_out_time,
    output logic [IDX_W-1:0]  wave_out_idx,
    input  logic              upd_en,
    input  logic [TIME_W-1:0] upd_time
);

    logic [TIME_W-1:0] free_time_reg;
    logic              wave_valid_reg;
    logic [TIME_W-1:0] wave_time_reg;
    logic [IDX_W-1:0]  wave_idx_reg;
    logic              take;

    // Strict less-than keeps the lower index on equal times.
    assign take = active && (free_time_reg < wave_in_time);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_time_reg  <= '0;
            wave_valid_reg <= 1'b0;
        end
        else
        begin
            wave_valid_reg <= wave_in_valid;
            if (upd_en)
            begin
                free_time_reg <= upd_time;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            wave_time_reg <= free_time_reg;
            wave_idx_reg  <= IDX_W'(INDEX);
        end
        else
        begin
            wave_time_reg <= wave_in_time;
            wave_idx_reg  <= wave_in_idx;
        end
    end

    assign wave_out_valid = wave_valid_reg;
    assign wave_out_time  = wave_time_reg;
    assign wave_out_idx   = wave_idx_reg;

endmodule

// ===== rtl/efws_chain.sv =====
// Row of worker cells with the update decode and active-worker mask.
module efws_chain
    import efws_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF,
    parameter int IDX_W       = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  count,
    input  logic              launch,
    output logic              best_valid,
    output logic [TIME_W-1:0] best_time,
    output logic [IDX_W-1:0]  best_idx,
    input  logic              upd_en,
    input  logic [IDX_W-1:0]  upd_idx,
    input  logic [TIME_W-1:0] upd_time
);

    logic              wv [0:MAX_WORKERS];
    logic [TIME_W-1:0] wt [0:MAX_WORKERS];
    logic [IDX_W-1:0]  wi [0:MAX_WORKERS];

    // Start the wave at the largest time so worker 0 always wins ties.
    assign wv[0] = launch;
    assign wt[0] = TIME_MAX;
    assign wi[0] = '0;

    for (genvar k = 0; k < MAX_WORKERS; k++)
    begin : g_cell
        logic act;
        logic hit;

        // A count of zero still leaves worker 0 active.
        assign act = (k == 0) || (32'(k) < 32'(count));
        assign hit = upd_en && (upd_idx == IDX_W'(k));

        efws_cell #(
            .INDEX (k),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .active         (act),
            .wave_in_valid  (wv[k]),
            .wave_in_time   (wt[k]),
            .wave_in_idx    (wi[k]),
            .wave_out_valid (wv[k+1]),
            .wave_out_time  (wt[k+1]),
            .wave_out_idx   (wi[k+1]),
            .upd_en         (hit),
            .upd_time       (upd_time)
        );
    end

    assign best_valid = wv[MAX_WORKERS];
    assign best_time  = wt[MAX_WORKERS];
    assign best_idx   = wi[MAX_WORKERS];

endmodule

// ===== rtl/earliest_free_worker_scheduler_top.sv =====
// Earliest-free worker scheduler: one job in, one worker assignment out.
//
// Each accepted job goes to the active worker with the smallest next-free
// time, lowest index on ties; the result carries that worker and its start
// time, and the worker's free time then grows by the job duration,
// saturating at 2^63-1. A compare wave walks the row of MAX_WORKERS cells,
// one cell per cycle; its minimum is registered as the scan result and
// then loaded into the output register, and a new job is accepted only
// after the previous result has been loaded there. The output register
// lets the next job start its scan while a result waits. The worker count
// register resets to 16; 0 acts as 1 and values above MAX_WORKERS act as
// MAX_WORKERS. Write it only while no job is in flight.
module earliest_free_worker_scheduler_top
    import efws_pkg::*;
#(
    parameter int MAX_WORKERS = MAX_WORKERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DUR_W-1:0]    duration,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORKER_W-1:0] worker,
    output logic [TIME_W-1:0]   start_time
);

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]    active_reg;
    logic [DUR_W-1:0]    dur_reg;
    logic [TIME_W-1:0]   best_time_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                out_valid_reg;
    logic [WORKER_W-1:0] worker_reg;
    logic [TIME_W-1:0]   start_time_reg;

    logic              launch;
    logic              capture;
    logic              release_beat;
    logic              out_free;
    logic              chain_valid;
    logic [TIME_W-1:0] chain_time;
    logic [IDX_W-1:0]  chain_idx;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] upd_time;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= CNT_RESET;
        end
        else if (cfg_valid)
        begin
            active_reg <= cfg_data;
        end
    end

    efws_chain #(
        .MAX_WORKERS (MAX_WORKERS),
        .IDX_W       (IDX_W)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .count      (active_reg),
        .launch     (launch),
        .best_valid (chain_valid),
        .best_time  (chain_time),
        .best_idx   (chain_idx),
        .upd_en     (release_beat),
        .upd_idx    (best_idx_reg),
        .upd_time   (upd_time)
    );

    // Start below 2^63 and duration below 2^32: the sum cannot wrap 64 bits.
    assign sum      = {1'b0, best_time_reg} + (TIME_W+1)'(dur_reg);
    assign upd_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chain_valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        launch       = 1'b0;
        capture      = 1'b0;
        release_beat = 1'b0;
        in_stall     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                launch   = in_valid;
            end
            ST_SCAN:
            begin
                capture = chain_valid;
            end
            ST_DONE:
            begin
                release_beat = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (release_beat)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            dur_reg <= duration;
        end
        if (capture)
        begin
            best_time_reg <= chain_time;
            best_idx_reg  <= chain_idx;
        end
        if (release_beat)
        begin
            worker_reg     <= WORKER_W'(best_idx_reg);
            start_time_reg <= best_time_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign worker     = worker_reg;
    assign start_time = start_time_reg;

    a_wave_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid |-> state_reg == ST_SCAN)
        else $error("compare wave finished outside a scan");

    a_no_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        release_beat |-> upd_time >= best_time_reg)
        else $error("worker free time moved backward");

    a_active_pick: assert property (@(posedge clk) disable iff (!rst_n)
        release_beat |-> (best_idx_reg == '0 || 32'(best_idx_reg) < 32'(active_reg)))
        else $error("inactive worker picked");

    a_start_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        release_beat |=> out_valid_reg && start_time_reg == $past(best_time_reg))
        else $error("result beat not loaded from scan minimum");

endmodule
